// ===== design/fbsg_pkg.sv =====
package fbsg_pkg;

  localparam int unsigned BOOT_SECTOR_BYTES = 512;
  localparam int unsigned POS_W = 10;

  localparam logic [15:0] BOOT_SIGNATURE = 16'hAA55;
  localparam logic [31:0] FAT12_MAX_CLUSTERS = 32'd4085;
  localparam logic [31:0] FAT16_MAX_CLUSTERS = 32'd65525;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_SIG = 2'd1;
  localparam logic [1:0] STATUS_ZERO    = 2'd2;

  localparam logic [1:0] KIND_FAT12 = 2'd0;
  localparam logic [1:0] KIND_FAT16 = 2'd1;
  localparam logic [1:0] KIND_FAT32 = 2'd2;

  typedef struct packed {
    logic capture;
    logic load_mul;
    logic div_start_root;
    logic div_start_clus;
    logic take_root;
    logic take_clus;
    logic sum_base;
    logic sum_data;
    logic sum_diff;
    logic emit;
  } fbsg_cmd_t;

  typedef struct packed {
    logic div_done;
  } fbsg_stat_t;

endpackage

// ===== design/fbsg_div.sv =====
module fbsg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dvs_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_r, quo_r[31]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // one quotient bit per cycle, restoring
      rem_nxt = fits ? 16'(trial - {1'b0, dvs_r}) : trial[15:0];
      quo_nxt = {quo_r[30:0], fits};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/fbsg_datapath.sv =====
module fbsg_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fbsg_pkg::fbsg_cmd_t   cmd,
  output fbsg_pkg::fbsg_stat_t  stat,
  input  logic [7:0]            in_byte,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [1:0]            out_fat_kind,
  output logic [15:0]           out_fat_start_sector,
  output logic [31:0]           out_root_dir_start_sector,
  output logic [15:0]           out_root_dir_sector_count,
  output logic [31:0]           out_data_start_sector,
  output logic [31:0]           out_cluster_count,
  output logic [31:0]           out_total_sector_count,
  output logic [31:0]           out_root_start_cluster,
  output logic [7:0]            out_cluster_sectors,
  output logic [15:0]           out_sector_bytes,
  output logic [7:0]            out_fat_copies
);

  localparam logic [9:0] SIG_LO = 10'(fbsg_pkg::BOOT_SECTOR_BYTES - 2);
  localparam logic [9:0] SIG_HI = 10'(fbsg_pkg::BOOT_SECTOR_BYTES - 1);
  localparam logic [9:0] POS_END = 10'(fbsg_pkg::BOOT_SECTOR_BYTES);

  logic [fbsg_pkg::POS_W-1:0] pos_r;
  logic [15:0] bps_r, rsvd_r, rent_r, tot16_r, fsz16_r, sig_r;
  logic [7:0]  spc_r, nf_r;
  logic [31:0] tot32_r, fsz32_r, rclus_r;

  logic [31:0] fat_secs_r, num_r, rcprod_r, root_secs_r, base_r, data_r;
  logic [31:0] diff_r, rs32_r, clus_r;
  logic        valid_r;

  logic        long_mode;
  logic [31:0] total;
  logic [31:0] fat_size;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_start;
  logic        div_done;
  logic [31:0] div_q;

  assign long_mode = tot16_r == 16'd0;
  assign total     = long_mode ? tot32_r : {16'd0, tot16_r};
  assign fat_size  = long_mode ? fsz32_r : {16'd0, fsz16_r};

  assign div_start    = cmd.div_start_root | cmd.div_start_clus;
  assign div_dividend = cmd.div_start_clus ? diff_r : num_r;
  assign div_divisor  = cmd.div_start_clus ? {8'd0, spc_r} : bps_r;

  fbsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign stat.div_done = div_done;

  // field capture at fixed offsets, little endian
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      pos_r   <= '0;
      bps_r   <= '0;
      spc_r   <= '0;
      rsvd_r  <= '0;
      nf_r    <= '0;
      rent_r  <= '0;
      tot16_r <= '0;
      fsz16_r <= '0;
      tot32_r <= '0;
      fsz32_r <= '0;
      rclus_r <= '0;
      sig_r   <= '0;
    end else if (cmd.capture && pos_r != POS_END) begin
      pos_r <= pos_r + 10'd1;
      if (pos_r == 10'd11) bps_r[7:0] <= in_byte;
      if (pos_r == 10'd12) bps_r[15:8] <= in_byte;
      if (pos_r == 10'd13) spc_r <= in_byte;
      if (pos_r == 10'd14) rsvd_r[7:0] <= in_byte;
      if (pos_r == 10'd15) rsvd_r[15:8] <= in_byte;
      if (pos_r == 10'd16) nf_r <= in_byte;
      if (pos_r == 10'd17) rent_r[7:0] <= in_byte;
      if (pos_r == 10'd18) rent_r[15:8] <= in_byte;
      if (pos_r == 10'd19) tot16_r[7:0] <= in_byte;
      if (pos_r == 10'd20) tot16_r[15:8] <= in_byte;
      if (pos_r == 10'd22) fsz16_r[7:0] <= in_byte;
      if (pos_r == 10'd23) fsz16_r[15:8] <= in_byte;
      if (pos_r[9:2] == 8'd8)  tot32_r[pos_r[1:0]*8 +: 8] <= in_byte;
      if (pos_r[9:2] == 8'd9)  fsz32_r[pos_r[1:0]*8 +: 8] <= in_byte;
      if (pos_r[9:2] == 8'd11) rclus_r[pos_r[1:0]*8 +: 8] <= in_byte;
      if (pos_r == SIG_LO) sig_r[7:0] <= in_byte;
      if (pos_r == SIG_HI) sig_r[15:8] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      fat_secs_r <= 32'(fat_size * {24'd0, nf_r});
      num_r      <= {11'd0, rent_r, 5'd0} + {16'd0, bps_r} - 32'd1;
      rcprod_r   <= 32'((rclus_r - 32'd2) * {24'd0, spc_r});
    end
    if (cmd.take_root)
      root_secs_r <= (long_mode || bps_r == 16'd0) ? 32'd0 : div_q;
    if (cmd.take_clus)
      clus_r <= (spc_r == 8'd0) ? 32'd0 : div_q;
    if (cmd.sum_base) base_r <= {16'd0, rsvd_r} + fat_secs_r;
    if (cmd.sum_data) data_r <= base_r + root_secs_r;
    if (cmd.sum_diff) begin
      diff_r <= total - data_r;
      rs32_r <= data_r + rcprod_r;
    end
    if (cmd.emit) begin
      priority if (sig_r != fbsg_pkg::BOOT_SIGNATURE)
        out_status <= fbsg_pkg::STATUS_BAD_SIG;
      else if (bps_r == 16'd0 || spc_r == 8'd0)
        out_status <= fbsg_pkg::STATUS_ZERO;
      else
        out_status <= fbsg_pkg::STATUS_OK;
      priority if (clus_r <= fbsg_pkg::FAT12_MAX_CLUSTERS)
        out_fat_kind <= fbsg_pkg::KIND_FAT12;
      else if (clus_r <= fbsg_pkg::FAT16_MAX_CLUSTERS)
        out_fat_kind <= fbsg_pkg::KIND_FAT16;
      else
        out_fat_kind <= fbsg_pkg::KIND_FAT32;
      out_fat_start_sector      <= rsvd_r;
      out_root_dir_start_sector <= long_mode ? rs32_r : base_r;
      out_root_dir_sector_count <= root_secs_r[15:0];
      out_data_start_sector     <= data_r;
      out_cluster_count         <= clus_r;
      out_total_sector_count    <= total;
      out_root_start_cluster    <= long_mode ? rclus_r : 32'd0;
      out_cluster_sectors       <= spc_r;
      out_sector_bytes          <= bps_r;
      out_fat_copies            <= nf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= cmd.emit;
  end

  assign out_valid = valid_r;

endmodule

// ===== design/fbsg_ctrl.sv =====
module fbsg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 last_byte,
  input  fbsg_pkg::fbsg_stat_t stat,
  output fbsg_pkg::fbsg_cmd_t  cmd,
  output logic                 busy
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_D1GO  = 4'd2;
  localparam logic [3:0] ST_D1WT  = 4'd3;
  localparam logic [3:0] ST_BASE  = 4'd4;
  localparam logic [3:0] ST_DATA  = 4'd5;
  localparam logic [3:0] ST_DIFF  = 4'd6;
  localparam logic [3:0] ST_D2GO  = 4'd7;
  localparam logic [3:0] ST_D2WT  = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign busy   = state_r != ST_IDLE;
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.capture = accept;
        if (accept && last_byte) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.load_mul = 1'b1;
        state_nxt    = ST_D1GO;
      end
      ST_D1GO: begin
        cmd.div_start_root = 1'b1;
        state_nxt          = ST_D1WT;
      end
      ST_D1WT: begin
        if (stat.div_done) begin
          cmd.take_root = 1'b1;
          state_nxt     = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.sum_base = 1'b1;
        state_nxt    = ST_DATA;
      end
      ST_DATA: begin
        cmd.sum_data = 1'b1;
        state_nxt    = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.sum_diff = 1'b1;
        state_nxt    = ST_D2GO;
      end
      ST_D2GO: begin
        cmd.div_start_clus = 1'b1;
        state_nxt          = ST_D2WT;
      end
      ST_D2WT: begin
        if (stat.div_done) begin
          cmd.take_clus = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== design/fat_boot_sector_geometry.sv =====
// Boot sector bytes are taken one per cycle while start is high and busy is
// low. After the beat flagged last, busy stays high while the geometry is
// computed: two passes of a 32-step restoring divider (root directory size,
// then cluster count), one after the other. out_valid pulses for a
// single cycle with the result in the first cycle that busy is low again, and
// a new beat may be accepted in that same cycle; the receiver cannot stall it.
module fat_boot_sector_geometry (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_sector_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [1:0]  out_fat_kind,
  output logic [15:0] out_fat_start_sector,
  output logic [31:0] out_root_dir_start_sector,
  output logic [15:0] out_root_dir_sector_count,
  output logic [31:0] out_data_start_sector,
  output logic [31:0] out_cluster_count,
  output logic [31:0] out_total_sector_count,
  output logic [31:0] out_root_start_cluster,
  output logic [7:0]  out_cluster_sectors,
  output logic [15:0] out_sector_bytes,
  output logic [7:0]  out_fat_copies
);

  fbsg_pkg::fbsg_cmd_t  cmd;
  fbsg_pkg::fbsg_stat_t stat;

  fbsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_byte (in_last_byte),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  fbsg_datapath u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .stat                      (stat),
    .in_byte                   (in_sector_byte),
    .out_valid                 (out_valid),
    .out_status                (out_status),
    .out_fat_kind              (out_fat_kind),
    .out_fat_start_sector      (out_fat_start_sector),
    .out_root_dir_start_sector (out_root_dir_start_sector),
    .out_root_dir_sector_count (out_root_dir_sector_count),
    .out_data_start_sector     (out_data_start_sector),
    .out_cluster_count         (out_cluster_count),
    .out_total_sector_count    (out_total_sector_count),
    .out_root_start_cluster    (out_root_start_cluster),
    .out_cluster_sectors       (out_cluster_sectors),
    .out_sector_bytes          (out_sector_bytes),
    .out_fat_copies            (out_fat_copies)
  );

  a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_byte |=> busy)
    else $error("last beat did not start computation");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result held more than one cycle");

  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without computation");

endmodule
